FILE: rtl/assert_macros.svh
// assertion macros for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/anw_pkg.sv
// shared types and constants for the ascii number to word parser
package anw_pkg;

  // character codes
  localparam logic [7:0] CH_NEWLINE        = 8'd10;
  localparam logic [7:0] CH_ZERO           = 8'd48;
  localparam logic [7:0] CH_MINUS          = 8'd45;
  localparam logic [7:0] CH_LOWER_A        = 8'd97;
  localparam logic [7:0] HEX_LETTER_OFFSET = 8'd87;

  // hex digit limit and counters
  localparam int         MAX_HEX_DIGITS = 8;
  localparam logic [4:0] HEX_LIMIT      = 5'(MAX_HEX_DIGITS);
  localparam logic [3:0] HEX_CNT_MAX    = 4'd15;
  localparam logic [4:0] POS_MAX        = 5'd31;
  localparam logic [4:0] HEX_FIRST_POS  = 5'd2;

  // character held in the input stage
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } anw_stage_t;

  // one parsed line
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] magnitude;
    logic        is_negative;
    logic        is_hex;
    logic [31:0] swapped;
  } anw_result_t;

endpackage

FILE: rtl/anw_if.sv
// valid/ready channels for characters in and parsed words out
interface anw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface anw_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [31:0] magnitude;
  logic        is_negative;
  logic        is_hex;
  logic [31:0] swapped;

  modport source (output valid, output word, output magnitude, output is_negative,
                  output is_hex, output swapped, input ready);
  modport sink   (input valid, input word, input magnitude, input is_negative,
                  input is_hex, input swapped, output ready);
endinterface

FILE: rtl/anw_in_reg.sv
// input register stage for incoming character beats
module anw_in_reg
  import anw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  anw_char_if.sink    in_if,
  input  logic        out_free,
  output anw_stage_t  stage,
  output logic        adv
);

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       take;

  // stage moves on when the result slot can take it
  assign adv         = valid_r && out_free;
  assign in_if.ready = !valid_r || adv;
  assign take        = in_if.valid && in_if.ready;

  // next stage contents
  always_comb begin
    valid_nxt = valid_r;
    ch_nxt    = ch_r;
    if (take) begin
      valid_nxt = 1'b1;
      ch_nxt    = in_if.char_in;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.ch    = ch_r;

endmodule

FILE: rtl/anw_parse.sv
// line state and per-character accumulation, result formed at newline
module anw_parse
  import anw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  ch,
  output logic        line_end,
  output anw_result_t res
);

  logic [31:0] acc_r, acc_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        hex_r, hex_nxt;
  logic        sign_r, sign_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [31:0] dec_digit, hex_digit, acc_x10, acc_x16;
  logic        neg;
  logic [31:0] word;

  // digit values and shift-add scaling
  assign dec_digit = {24'd0, ch} - {24'd0, CH_ZERO};
  assign hex_digit = (ch >= CH_LOWER_A) ? ({24'd0, ch} - {24'd0, HEX_LETTER_OFFSET})
                                        : dec_digit;
  assign acc_x10   = (acc_r << 3) + (acc_r << 1) + dec_digit;
  assign acc_x16   = (acc_r << 4) + hex_digit;

  assign line_end = (ch == CH_NEWLINE);

  // next line state
  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    hex_nxt  = hex_r;
    sign_nxt = sign_r;
    cnt_nxt  = cnt_r;
    if (step_en) begin
      if (line_end) begin
        acc_nxt  = '0;
        pos_nxt  = '0;
        hex_nxt  = 1'b0;
        sign_nxt = 1'b0;
        cnt_nxt  = '0;
      end else begin
        if (pos_r == '0 && ch == CH_ZERO) begin
          hex_nxt = 1'b1;
        end else if (hex_r) begin
          if (pos_r >= HEX_FIRST_POS && {1'b0, cnt_r} < HEX_LIMIT) begin
            acc_nxt = acc_x16;
            if (cnt_r != HEX_CNT_MAX) begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
        end else if (pos_r == '0 && ch == CH_MINUS) begin
          sign_nxt = 1'b1;
        end else begin
          acc_nxt = acc_x10;
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 5'd1;
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pos_r  <= '0;
      hex_r  <= 1'b0;
      sign_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      hex_r  <= hex_nxt;
      sign_r <= sign_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result from the state before the newline
  assign neg  = !hex_r && sign_r;
  assign word = neg ? (32'd0 - acc_r) : acc_r;

  assign res.word        = word;
  assign res.magnitude   = acc_r;
  assign res.is_negative = neg;
  assign res.is_hex      = hex_r;
  assign res.swapped     = {word[7:0], word[15:8], word[23:16], word[31:24]};

endmodule

FILE: rtl/anw_out_reg.sv
// result register driving the output channel
module anw_out_reg
  import anw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  anw_result_t res,
  anw_result_if.source out_if,
  output logic        out_free
);

  logic        valid_r, valid_nxt;
  anw_result_t res_r, res_nxt;

  // slot is free when empty or drained this cycle
  assign out_free = !valid_r || out_if.ready;

  // next slot contents
  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_if.valid       = valid_r;
  assign out_if.word        = res_r.word;
  assign out_if.magnitude   = res_r.magnitude;
  assign out_if.is_negative = res_r.is_negative;
  assign out_if.is_hex      = res_r.is_hex;
  assign out_if.swapped     = res_r.swapped;

endmodule

FILE: rtl/ascii_number_to_word_core.sv
// A newline beat is registered in the input stage, then in the result register once the slot is free.
// Throughput: one character beat per cycle, set by the combinational shift-add
// accumulate step; a result held by the sink stalls every following beat.
// Reset: synchronous, active low; clears the stage and result valid flags and
// the line state (accumulator, position, hex mode, sign, hex digit count).
`include "assert_macros.svh"

module ascii_number_to_word_core
  import anw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  anw_char_if.sink     in_if,
  anw_result_if.source out_if
);

  anw_stage_t  stage;
  logic        adv;
  logic        out_free;
  logic        line_end;
  anw_result_t res;
  logic        load;

  // input stage
  anw_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_free (out_free),
    .stage    (stage),
    .adv      (adv)
  );

  // parser
  anw_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (adv),
    .ch       (stage.ch),
    .line_end (line_end),
    .res      (res)
  );

  // result slot loads on a newline beat
  assign load = adv && line_end;

  anw_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .res      (res),
    .out_if   (out_if),
    .out_free (out_free)
  );

  // checks
  `ASSERT_NEXT(a_newline_gives_result, clk, rst_n, load, out_if.valid, "newline lost")
  `ASSERT_IMPLIES(a_hex_never_negative, clk, rst_n, out_if.valid, !(out_if.is_hex && out_if.is_negative), "hex line marked negative")
  `ASSERT_IMPLIES(a_word_matches_mag, clk, rst_n, out_if.valid && !out_if.is_negative, out_if.word == out_if.magnitude, "word differs from magnitude")
  `ASSERT_NEXT(a_stage_holds, clk, rst_n, stage.valid && !adv, stage.valid && $stable(stage.ch), "stalled character lost")

endmodule

FILE: tb/tb_ascii_number_to_word_core.sv
// self-checking testbench for the ascii number to word parser core
module tb_ascii_number_to_word_core;
  timeunit 1ns;
  timeprecision 1ps;
  import anw_pkg::*;

  localparam int CHAR_TARGET   = 1950;
  localparam int IDLE_PCT      = 27;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_LINE  = 60;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  // one directed line: text, an optional raw trailing byte, and a typed result
  typedef struct {
    string       text;
    bit          tail_on;
    logic [7:0]  tail;
    bit          known;
    anw_result_t want;
  } text_row_t;

  logic clk;
  logic rst_n;

  anw_char_if   char_ch ();
  anw_result_if word_ch ();

  ascii_number_to_word_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (char_ch),
    .out_if (word_ch)
  );

  // line parser state mirrored in the testbench
  logic [31:0] line_acc;
  logic [4:0]  line_pos;
  logic        line_is_hex;
  logic        line_minus;
  logic [3:0]  hex_used;

  anw_result_t lines_due [$];
  text_row_t   dir_rows [$];

  int chars_sent;
  int lines_checked;
  int hex_lines;
  int neg_lines;
  int mismatches;
  int cycles;
  int hold_left;
  bit held_once;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ascii_number_to_word_core regression: fail");
      $finish;
    end
  end

  // parse one character; returns 1 and the finished line on newline
  function automatic bit parse_char(input logic [7:0] c, output anw_result_t parsed);
    logic [31:0] digit;
    logic [31:0] w;
    logic        neg;
    parsed = '0;
    if (c == CH_NEWLINE) begin
      neg = line_is_hex ? 1'b0 : line_minus;
      w = neg ? (32'd0 - line_acc) : line_acc;
      parsed.word        = w;
      parsed.magnitude   = line_acc;
      parsed.is_negative = neg;
      parsed.is_hex      = line_is_hex;
      parsed.swapped     = {w[7:0], w[15:8], w[23:16], w[31:24]};
      line_acc    = '0;
      line_pos    = '0;
      line_is_hex = 1'b0;
      line_minus  = 1'b0;
      hex_used    = '0;
      return 1'b1;
    end
    if (line_pos == '0 && c == CH_ZERO) begin
      line_is_hex = 1'b1;
    end else if (line_is_hex) begin
      // prefix skipped, digits past the limit dropped
      if (line_pos >= HEX_FIRST_POS && hex_used < MAX_HEX_DIGITS) begin
        digit = (c >= CH_LOWER_A) ? 32'(c) - 32'(HEX_LETTER_OFFSET)
                                  : 32'(c) - 32'(CH_ZERO);
        line_acc = line_acc * 32'd16 + digit;
        if (hex_used != HEX_CNT_MAX) hex_used = hex_used + 4'd1;
      end
    end else if (line_pos == '0 && c == CH_MINUS) begin
      line_minus = 1'b1;
    end else begin
      // any other char counts as a digit, wrapped
      line_acc = line_acc * 32'd10 + (32'(c) - 32'(CH_ZERO));
    end
    if (line_pos != POS_MAX) line_pos = line_pos + 5'd1;
    return 1'b0;
  endfunction

  // offer one character beat; the expectation is queued when it is taken
  task automatic offer_char(input logic [7:0] c, input bit typed, input anw_result_t typed_want);
    anw_result_t parsed;
    bit          calm;
    calm = (chars_sent >= 700 && chars_sent < 1100);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid   <= 1'b1;
    char_ch.char_in <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
    if (parse_char(c, parsed)) lines_due.push_back(typed ? typed_want : parsed);
  endtask

  // one random line: mostly well formed decimal or hex, some noise
  task automatic send_random_line();
    string hex_set;
    int    kind;
    int    n;
    hex_set = "0123456789abcdef";
    kind = $urandom_range(99);
    n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    if (kind < 40) begin
      // decimal, optional sign
      if ($urandom_range(3) == 0) begin
        offer_char(CH_MINUS, 1'b0, '0);
        if (n > 0) offer_char(8'(CH_ZERO + $urandom_range(9)), 1'b0, '0);
      end else if (n > 0) begin
        offer_char(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0, '0);
      end
      for (int i = 1; i < n; i++) offer_char(8'(CH_ZERO + $urandom_range(9)), 1'b0, '0);
    end else if (kind < 80) begin
      // hex with prefix
      offer_char(CH_ZERO, 1'b0, '0);
      if (n > 0 || $urandom_range(1) == 1)
        offer_char(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : "x", 1'b0, '0);
      for (int i = 0; i < n; i++) offer_char(hex_set[$urandom_range(15)], 1'b0, '0);
    end else if (kind < 92) begin
      // raw noise, may hold its own newlines
      for (int i = 0; i < (n % 9); i++) offer_char(8'($urandom_range(255)), 1'b0, '0);
    end else begin
      // broken line: a proper start, then stray characters
      case ($urandom_range(2))
        0: offer_char(CH_ZERO, 1'b0, '0);
        1: offer_char(CH_MINUS, 1'b0, '0);
        default: offer_char(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0, '0);
      endcase
      for (int i = 0; i < (n % 7); i++) offer_char(8'($urandom_range(32, 126)), 1'b0, '0);
    end
    offer_char(CH_NEWLINE, 1'b0, '0);
  endtask

  // result sink: compares each beat and drives ready, with one long hold-off
  always @(posedge clk) begin
    anw_result_t got;
    anw_result_t want;
    bit          calm;
    if (rst_n && word_ch.valid && word_ch.ready) begin
      got = {word_ch.word, word_ch.magnitude, word_ch.is_negative, word_ch.is_hex,
             word_ch.swapped};
      if (lines_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: word %h mag %h neg %b hex %b swap %h",
                   got.word, got.magnitude, got.is_negative, got.is_hex, got.swapped);
      end else begin
        want = lines_due.pop_front();
        if (want.is_hex) hex_lines++;
        if (want.is_negative) neg_lines++;
        if (got.word !== want.word || got.magnitude !== want.magnitude ||
            got.is_negative !== want.is_negative || got.is_hex !== want.is_hex ||
            got.swapped !== want.swapped) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("line %0d mismatch, expected: word %h mag %h neg %b hex %b swap %h",
                     lines_checked, want.word, want.magnitude, want.is_negative,
                     want.is_hex, want.swapped);
            $display("line %0d mismatch, actual:   word %h mag %h neg %b hex %b swap %h",
                     lines_checked, got.word, got.magnitude, got.is_negative,
                     got.is_hex, got.swapped);
          end
        end
      end
      lines_checked++;
    end
    calm = (lines_checked >= 140 && lines_checked < 220);
    if (hold_left != 0) begin
      hold_left--;
      word_ch.ready <= 1'b0;
    end else if (!held_once && lines_checked == HOLD_AT_LINE) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      word_ch.ready <= 1'b0;
    end else begin
      word_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // stimulus and end of run
  initial begin
    rst_n           <= 1'b0;
    char_ch.valid   <= 1'b0;
    char_ch.char_in <= 8'h00;
    line_acc    = '0;
    line_pos    = '0;
    line_is_hex = 1'b0;
    line_minus  = 1'b0;
    hex_used    = '0;

    // typed results in field order: word, magnitude, is_negative, is_hex, swapped
    dir_rows.push_back('{"", 1'b0, 8'h00, 1'b1,
                         {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}});
    dir_rows.push_back('{"-", 1'b0, 8'h00, 1'b1,
                         {32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}});
    dir_rows.push_back('{"0", 1'b0, 8'h00, 1'b1,
                         {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000}});
    dir_rows.push_back('{"4294967295", 1'b0, 8'h00, 1'b1,
                         {32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF}});
    dir_rows.push_back('{"0x123456789", 1'b0, 8'h00, 1'b1,
                         {32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1, 32'h7856_3412}});
    dir_rows.push_back('{"-1", 1'b0, 8'h00, 1'b1,
                         {32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 32'hFFFF_FFFF}});
    // minus in the middle and a top byte, then a nul inside a hex line
    dir_rows.push_back('{"9-", 1'b1, 8'hFF, 1'b0, '0});
    dir_rows.push_back('{"0x", 1'b1, 8'h00, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        offer_char(dir_rows[r].text[i], 1'b0, '0);
      if (dir_rows[r].tail_on) offer_char(dir_rows[r].tail, 1'b0, '0);
      offer_char(CH_NEWLINE, dir_rows[r].known, dir_rows[r].want);
    end

    // random lines
    while (chars_sent < CHAR_TARGET) send_random_line();
    char_ch.valid <= 1'b0;

    // drain
    while (lines_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters, checked %0d lines (%0d hex, %0d negative)",
             chars_sent, lines_checked, hex_lines, neg_lines);
    $display("result side held off once for %0d cycles, %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && lines_due.size() == 0) begin
      $display("ascii_number_to_word_core regression: pass");
    end else begin
      $display("ascii_number_to_word_core regression: fail");
    end
    $finish;
  end

endmodule
